### rtl/sweep_pulse_record_packer_assert.svh
// ----------------------------------------------------------------------------
// Sweep pulse record packer assertion macros
// Concurrent checks on i_clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef SWEEP_PULSE_RECORD_PACKER_ASSERT_SVH
`define SWEEP_PULSE_RECORD_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is held off while reset is asserted
`define SPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds during reset
`define SPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SPR_ASSERT(lbl, prop, msg)
`define SPR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// Sweep pulse record packer package
// Field widths, constants and the structs passed between the packer modules.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int unsigned NUM_SENSORS = 4;
    localparam int unsigned SENS_W      = 2;
    localparam int unsigned TIME_W      = 24;
    localparam int unsigned WIDTH_W     = 16;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned SYNC_W      = 19;
    localparam int unsigned REC_SYNC_W  = 17;
    localparam int unsigned MID_W       = 25;
    localparam int unsigned DELTA_W     = 16;

    localparam logic [DELTA_W-1:0]     SAT_DELTA = 16'h7FFF;
    localparam logic [15:0]            GAP_LIMIT = 16'hFFFF;
    localparam logic [NUM_SENSORS-1:0] ALL_SEEN  = 4'hF;

    // command codes
    localparam logic CMD_PULSE   = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SENS_W-1:0]   sensor_index;
        logic [TIME_W-1:0]   pulse_time;
        logic [WIDTH_W-1:0]  pulse_width;
        logic                channel_found;
        logic [CHAN_W-1:0]   base_channel;
        logic                slow_bit;
        logic [SYNC_W-1:0]   sync_offset_in;
    } t_item;

    // State captured for one closed record
    typedef struct packed {
        logic [CHAN_W-1:0]                  channel;
        logic                               slow;
        logic [SYNC_W-1:0]                  sync;
        logic [TIME_W-1:0]                  ref_time;
        logic [NUM_SENSORS-1:0][MID_W-1:0]  mid;
        logic [NUM_SENSORS-1:0]             seen;
    } t_snap;

    typedef struct packed {
        logic res_valid;
        logic has_record;
        logic packet_end;
    } t_close;

    typedef struct packed {
        logic                               has_record;
        logic [CHAN_W-1:0]                  rec_channel;
        logic                               rec_slow_bit;
        logic [REC_SYNC_W-1:0]              rec_sync;
        logic [TIME_W-1:0]                  rec_ref_time;
        logic [NUM_SENSORS-1:0][DELTA_W-1:0] delta;
        logic                               packet_end;
    } t_rec;

endpackage

### rtl/sweep_pulse_record_packer.sv
// ----------------------------------------------------------------------------
// Sweep pulse record packer
// Groups optical sweep pulse frames into records and marks packet ends.
// ----------------------------------------------------------------------------
// One item (pulse frame or timeout tick) is taken every clock cycle. Each
// item passes an input register, then the tracking and record logic, and a
// record lands in the result register. The result register stalls only
// while its result is not taken; the input side keeps accepting as long as
// the result register can drain. Items that close no record and end no
// packet produce no output transfer. With stream_enable low every item is
// consumed without effect.
// ----------------------------------------------------------------------------
module sweep_pulse_record_packer
    import spr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_stream_enable,
    // frame input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic [SENS_W-1:0]         i_sensor_index,
    input  logic [TIME_W-1:0]         i_pulse_time,
    input  logic [WIDTH_W-1:0]        i_pulse_width,
    input  logic                      i_channel_found,
    input  logic [CHAN_W-1:0]         i_base_channel,
    input  logic                      i_slow_bit,
    input  logic [SYNC_W-1:0]         i_sync_offset_in,
    // record output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_has_record,
    output logic [CHAN_W-1:0]         o_rec_channel,
    output logic                      o_rec_slow_bit,
    output logic [REC_SYNC_W-1:0]     o_rec_sync,
    output logic [TIME_W-1:0]         o_rec_ref_time,
    output logic signed [DELTA_W-1:0] o_delta_s0,
    output logic signed [DELTA_W-1:0] o_delta_s1,
    output logic signed [DELTA_W-1:0] o_delta_s2,
    output logic signed [DELTA_W-1:0] o_delta_s3,
    output logic                      o_packet_end
);

`include "sweep_pulse_record_packer_assert.svh"

    logic   r_enable;
    logic   r_out_valid;
    t_rec   r_rec;

    t_item  w_in_item;
    t_item  w_item;
    logic   w_item_valid;
    logic   w_advance;
    logic   w_load;
    t_close w_close;
    t_snap  w_snap;
    t_rec   w_rec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_stream_enable;
        end
    end

    assign w_in_item = '{cmd: i_cmd, sensor_index: i_sensor_index,
                         pulse_time: i_pulse_time, pulse_width: i_pulse_width,
                         channel_found: i_channel_found, base_channel: i_base_channel,
                         slow_bit: i_slow_bit, sync_offset_in: i_sync_offset_in};

    // item leaves the input register once the result register has room
    assign w_advance = w_item_valid && (!r_out_valid || i_out_ready);
    assign w_load    = w_advance && w_close.res_valid;

    spr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    spr_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_enable),
        .i_fire   (w_advance),
        .i_item   (w_item),
        .o_close  (w_close),
        .o_snap   (w_snap)
    );

    spr_rec_build u_rec_build (
        .i_snap  (w_snap),
        .i_close (w_close),
        .o_rec   (w_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rec <= w_rec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_record   = r_rec.has_record;
    assign o_rec_channel  = r_rec.rec_channel;
    assign o_rec_slow_bit = r_rec.rec_slow_bit;
    assign o_rec_sync     = r_rec.rec_sync;
    assign o_rec_ref_time = r_rec.rec_ref_time;
    assign o_delta_s0     = $signed(r_rec.delta[0]);
    assign o_delta_s1     = $signed(r_rec.delta[1]);
    assign o_delta_s2     = $signed(r_rec.delta[2]);
    assign o_delta_s3     = $signed(r_rec.delta[3]);
    assign o_packet_end   = r_rec.packet_end;

    // every output transfer carries a record or ends a packet
    `SPR_ASSERT(a_out_not_empty, o_out_valid |-> (o_has_record || o_packet_end),
                "empty result")
    // a bare packet end carries cleared record fields
    `SPR_ASSERT(a_bare_end_zero,
                (o_out_valid && !o_has_record) |->
                (o_rec_ref_time == '0 && o_rec_sync == '0 && r_rec.delta == '0),
                "bare packet end with stale fields")
    // a new result only follows an item consumed while enabled
    `SPR_ASSERT(a_load_enabled, $rose(o_out_valid) |-> $past(w_advance && r_enable),
                "result without enabled item")
    // a full input register that cannot drain must not take another transfer
    `SPR_ASSERT_ALWAYS(a_in_hold, (w_item_valid && !w_advance) |-> !o_in_ready,
                       "input overrun")

endmodule

### rtl/spr_in_reg.sv
// ----------------------------------------------------------------------------
// Sweep pulse record packer input register
// Holds one accepted frame until the tracker consumes it.
// ----------------------------------------------------------------------------
module spr_in_reg
    import spr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/spr_tracker.sv
// ----------------------------------------------------------------------------
// Sweep pulse record packer tracker
// Keeps channel, reference time, sync and per-sensor mid times, and decides
// when a record closes and when a packet ends.
// ----------------------------------------------------------------------------
module spr_tracker
    import spr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enable,
    input  logic   i_fire,
    input  t_item  i_item,
    output t_close o_close,
    output t_snap  o_snap
);

    logic                               r_cv, n_cv;
    logic [CHAN_W-1:0]                  r_ch, n_ch;
    logic                               r_slow, n_slow;
    logic [TIME_W-1:0]                  r_ref, n_ref;
    logic [TIME_W-1:0]                  r_prev, n_prev;
    logic [SYNC_W-1:0]                  r_sync, n_sync;
    logic [NUM_SENSORS-1:0][MID_W-1:0]  r_mid, n_mid;
    logic [NUM_SENSORS-1:0]             r_seen, n_seen;
    logic                               r_pend, n_pend;

    // frame path intermediates
    logic [MID_W-1:0]                   w_gap;
    logic                               w_close_gap;
    logic                               w_cv1;
    logic [TIME_W-1:0]                  w_ref1;
    logic [SYNC_W-1:0]                  w_sync1;
    logic [NUM_SENSORS-1:0]             w_seen1;
    logic                               w_close_chan;
    logic                               w_close_ab;
    logic                               w_cv2;
    logic [CHAN_W-1:0]                  w_ch2;
    logic                               w_slow2;
    logic [TIME_W-1:0]                  w_ref2;
    logic [SYNC_W-1:0]                  w_sync2;
    logic [NUM_SENSORS-1:0]             w_seen2;
    logic [SYNC_W-1:0]                  w_sync3;
    logic [TIME_W-1:0]                  w_ref3;
    logic [NUM_SENSORS-1:0][MID_W-1:0]  w_mid3;
    logic [NUM_SENSORS-1:0]             w_seen3;
    logic                               w_close_full;
    logic                               w_has_sync;
    t_snap                              w_old_snap;
    t_snap                              w_new_snap;

    // gap only counts when the frame is later than the reference time
    assign w_gap       = {1'b0, i_item.pulse_time} - {1'b0, r_prev};
    assign w_close_gap = r_cv && (i_item.pulse_time > r_ref) && !w_gap[MID_W-1]
                         && (w_gap[TIME_W-1:0] > {{(TIME_W-16){1'b0}}, GAP_LIMIT});

    assign w_cv1   = r_cv && !w_close_gap;
    assign w_ref1  = w_close_gap ? '0 : r_ref;
    assign w_sync1 = w_close_gap ? '0 : r_sync;
    assign w_seen1 = w_close_gap ? '0 : r_seen;

    assign w_close_chan = i_item.channel_found && w_cv1 && (r_ch != i_item.base_channel);
    assign w_close_ab   = w_close_gap || w_close_chan;

    // slow bit is only taken when a channel is first found
    assign w_cv2   = i_item.channel_found || w_cv1;
    assign w_ch2   = i_item.channel_found ? i_item.base_channel : r_ch;
    assign w_slow2 = (i_item.channel_found && !w_cv1) ? i_item.slow_bit : r_slow;
    assign w_ref2  = (i_item.channel_found && (!w_cv1 || w_close_chan))
                     ? i_item.pulse_time : w_ref1;
    assign w_sync2 = w_close_chan ? '0 : w_sync1;
    assign w_seen2 = w_close_chan ? '0 : w_seen1;

    assign w_has_sync = (i_item.sync_offset_in != '0);
    assign w_sync3    = w_has_sync ? i_item.sync_offset_in : w_sync2;
    assign w_ref3     = w_has_sync ? i_item.pulse_time : w_ref2;

    always_comb begin
        w_mid3 = r_mid;
        w_mid3[i_item.sensor_index] = MID_W'(i_item.pulse_time)
                                      + MID_W'(i_item.pulse_width[WIDTH_W-1:1]);
    end

    assign w_seen3 = w_seen2 | (NUM_SENSORS'(1) << i_item.sensor_index);

    // a full mask without a channel waits for a later frame that finds one
    assign w_close_full = (w_seen3 == ALL_SEEN) && !w_close_ab && w_cv2;

    assign w_old_snap = '{channel: r_ch, slow: r_slow, sync: r_sync, ref_time: r_ref,
                          mid: r_mid, seen: r_seen};
    assign w_new_snap = '{channel: w_ch2, slow: w_slow2, sync: w_sync3, ref_time: w_ref3,
                          mid: w_mid3, seen: w_seen3};

    always_comb begin
        n_cv    = r_cv;
        n_ch    = r_ch;
        n_slow  = r_slow;
        n_ref   = r_ref;
        n_prev  = r_prev;
        n_sync  = r_sync;
        n_mid   = r_mid;
        n_seen  = r_seen;
        n_pend  = r_pend;
        o_close = '0;
        o_snap  = w_old_snap;
        if (i_enable) begin
            if (i_item.cmd == CMD_TIMEOUT) begin
                if (r_cv) begin
                    // record plus flush: the packet always ends here
                    o_close = '{res_valid: 1'b1, has_record: 1'b1, packet_end: 1'b1};
                    n_cv    = 1'b0;
                    n_seen  = '0;
                    n_sync  = '0;
                    n_ref   = '0;
                    n_pend  = 1'b0;
                end else if (r_pend) begin
                    o_close = '{res_valid: 1'b1, has_record: 1'b0, packet_end: 1'b1};
                    n_pend  = 1'b0;
                end
            end else begin
                n_prev = i_item.pulse_time;
                n_ch   = w_ch2;
                n_slow = w_slow2;
                n_mid  = w_mid3;
                if (w_close_ab) begin
                    // old record goes out, the current frame opens the next one
                    o_close = '{res_valid: 1'b1, has_record: 1'b1, packet_end: r_pend};
                    o_snap  = w_old_snap;
                    n_cv    = w_cv2;
                    n_seen  = w_seen3;
                    n_sync  = w_sync3;
                    n_ref   = w_ref3;
                    n_pend  = !r_pend;
                end else if (w_close_full) begin
                    o_close = '{res_valid: 1'b1, has_record: 1'b1, packet_end: r_pend};
                    o_snap  = w_new_snap;
                    n_cv    = 1'b0;
                    n_seen  = '0;
                    n_sync  = '0;
                    n_ref   = '0;
                    n_pend  = !r_pend;
                end else begin
                    n_cv   = w_cv2;
                    n_seen = w_seen3;
                    n_sync = w_sync3;
                    n_ref  = w_ref3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= 1'b0;
            r_ch   <= '0;
            r_slow <= 1'b0;
            r_ref  <= '0;
            r_prev <= '0;
            r_sync <= '0;
            r_mid  <= '0;
            r_seen <= '0;
            r_pend <= 1'b0;
        end else if (i_fire) begin
            r_cv   <= n_cv;
            r_ch   <= n_ch;
            r_slow <= n_slow;
            r_ref  <= n_ref;
            r_prev <= n_prev;
            r_sync <= n_sync;
            r_mid  <= n_mid;
            r_seen <= n_seen;
            r_pend <= n_pend;
        end
    end

endmodule

### rtl/spr_rec_build.sv
// ----------------------------------------------------------------------------
// Sweep pulse record packer record builder
// Turns a closed-record snapshot into header fields and saturated deltas.
// ----------------------------------------------------------------------------
module spr_rec_build
    import spr_pkg::*;
(
    input  t_snap  i_snap,
    input  t_close i_close,
    output t_rec   o_rec
);

    localparam logic signed [MID_W:0] SAT_HI =
        $signed({{(MID_W+1-DELTA_W){1'b0}}, SAT_DELTA});
    localparam logic signed [MID_W:0] SAT_LO = -SAT_HI;

    logic signed [MID_W:0]               w_diff [NUM_SENSORS];
    logic [NUM_SENSORS-1:0][DELTA_W-1:0] w_delta;

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            w_diff[i] = $signed({1'b0, i_snap.mid[i]})
                        - $signed({2'b00, i_snap.ref_time});
            // missing sensor or a difference outside the open range saturates
            if (i_snap.seen[i] && (w_diff[i] < SAT_HI) && (w_diff[i] > SAT_LO)) begin
                w_delta[i] = w_diff[i][DELTA_W-1:0];
            end else begin
                w_delta[i] = SAT_DELTA;
            end
        end
    end

    always_comb begin
        o_rec = '0;
        o_rec.packet_end = i_close.packet_end;
        if (i_close.has_record) begin
            o_rec.has_record   = 1'b1;
            o_rec.rec_channel  = i_snap.channel;
            o_rec.rec_slow_bit = i_snap.slow;
            o_rec.rec_sync     = i_snap.sync[SYNC_W-1:2];
            o_rec.rec_ref_time = i_snap.ref_time;
            o_rec.delta        = w_delta;
        end
    end

endmodule
